// File: rtl/kdsl_pkg.sv
`timescale 1ns / 1ps

package kdsl_pkg;

   // one-hot key codes and the long press flag
   localparam logic [3:0] CODE_NONE  = 4'h0;
   localparam logic [3:0] CODE_POWER = 4'h1;
   localparam logic [3:0] CODE_MODE  = 4'h2;
   localparam logic [3:0] CODE_DEC   = 4'h4;
   localparam logic [3:0] CODE_ADD   = 4'h8;
   localparam logic [7:0] LONG_FLAG  = 8'h80;

   // hold count saturates here
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   // configuration register indexes and reset values
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_HOLD = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_HOLD  = 1'b1;
   localparam logic [15:0] SHORT_HOLD_RESET = 16'd40;
   localparam logic [15:0] LONG_HOLD_RESET  = 16'd800;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_DEB    = 3'd1,
      PH_TIME   = 3'd2,
      PH_REPORT = 3'd3,
      PH_WAIT   = 3'd4
   } phase_type;

   typedef struct packed {
      logic power_key_down;
      logic mode_key_down;
      logic dec_key_down;
      logic add_key_down;
      logic powered_up;
      logic interrupt_level;
   } item_type;

   typedef struct packed {
      logic       disable_touch;
      logic [7:0] key_code;
   } result_type;

endpackage

// File: rtl/kdsl_fsm.sv
`timescale 1ns / 1ps

module kdsl_fsm (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  kdsl_pkg::item_type   item,
   input  logic [15:0]          short_hold_ticks,
   input  logic [15:0]          long_hold_ticks,
   output kdsl_pkg::result_type result
);
   import kdsl_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [3:0]  held_key_ff, held_key_in;
   logic [15:0] hold_count_ff, hold_count_in;
   logic [7:0]  pending_code_ff, pending_code_in;

   logic [3:0]  sample;
   logic [15:0] count_inc;
   logic        same_key;
   logic        deb_done;
   logic        long_done;

   // priority: power, mode, dec, add
   always_comb begin
      if (item.power_key_down)     sample = CODE_POWER;
      else if (item.mode_key_down) sample = CODE_MODE;
      else if (item.dec_key_down)  sample = CODE_DEC;
      else if (item.add_key_down)  sample = CODE_ADD;
      else                         sample = CODE_NONE;
   end

   assign count_inc = (hold_count_ff == COUNT_MAX) ? hold_count_ff : hold_count_ff + 16'd1;
   assign same_key  = (sample == held_key_ff);
   assign deb_done  = (count_inc > short_hold_ticks);
   assign long_done = (count_inc > long_hold_ticks) && item.powered_up;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (sample != CODE_NONE) phase_in = PH_DEB;
         end
         PH_DEB: begin
            if (!same_key)     phase_in = PH_IDLE;
            else if (deb_done) phase_in = PH_TIME;
         end
         PH_TIME: begin
            if (same_key) begin
               if (long_done) phase_in = PH_REPORT;
            end else if (sample == CODE_NONE) begin
               phase_in = PH_REPORT;
            end
         end
         PH_REPORT: phase_in = PH_WAIT;
         PH_WAIT: begin
            if (sample == CODE_NONE) phase_in = PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   // counters, pending code and the result of this beat
   always_comb begin
      held_key_in     = held_key_ff;
      hold_count_in   = hold_count_ff;
      pending_code_in = pending_code_ff;
      result          = '0;
      case (phase_ff)
         PH_IDLE: begin
            if (sample != CODE_NONE) begin
               held_key_in   = sample;
               hold_count_in = '0;
            end
         end
         PH_DEB: begin
            if (same_key) begin
               if (deb_done) begin
                  hold_count_in   = '0;
                  pending_code_in = {4'b0000, held_key_ff};
               end else begin
                  hold_count_in = count_inc;
               end
            end else begin
               hold_count_in = '0;
            end
         end
         PH_TIME: begin
            if (same_key) begin
               if (long_done) begin
                  hold_count_in   = '0;
                  pending_code_in = pending_code_ff | LONG_FLAG;
               end else begin
                  hold_count_in = count_inc;
               end
            end else if (sample == CODE_NONE) begin
               pending_code_in = {4'b0000, held_key_ff};
            end
         end
         PH_REPORT: begin
            result.key_code      = pending_code_ff;
            result.disable_touch = !item.interrupt_level;
         end
         PH_WAIT: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         held_key_ff     <= '0;
         hold_count_ff   <= '0;
         pending_code_ff <= '0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         held_key_ff     <= held_key_in;
         hold_count_ff   <= hold_count_in;
         pending_code_ff <= pending_code_in;
      end
   end

   a_code_only_on_report : assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff != PH_REPORT) |-> result.key_code == 8'h00)
      else $error("key code outside report beat");

   a_touch_needs_code : assert property (@(posedge clock) disable iff (reset)
      (accept && result.disable_touch) |-> result.key_code != 8'h00)
      else $error("touch disabled without a key code");

   a_report_then_wait : assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_REPORT) |=> phase_ff == PH_WAIT)
      else $error("report not followed by wait");

   a_held_onehot : assert property (@(posedge clock) disable iff (reset)
      $onehot0(held_key_ff))
      else $error("tracked key not one-hot");

endmodule

// File: rtl/kdsl_rsp_reg.sv
`timescale 1ns / 1ps

module kdsl_rsp_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  kdsl_pkg::result_type load_data,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output kdsl_pkg::result_type rsp_data,
   output logic                 free
);
   import kdsl_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   // slot is free when empty or drained this cycle
   assign free     = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_data   = data_ff;

endmodule

// File: rtl/key_debounce_short_long_press.sv
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// req       in         req_tvalid/req_tready  tdata[5:0] key levels, powered_up, irq
// rsp       out        rsp_tvalid/rsp_tready  tdata[8:0] key_code, disable_touch
// csr       in         csr_valid/csr_ready    csr_index, csr_data (hold thresholds)
//
// one result beat per request beat, registered through the result register
// a new request beat is taken every cycle while the result register is empty or draining
// a stall on rsp holds req_tready low once the result register is full
// reset (synchronous, active high) returns to idle, thresholds to 40 and 800 ticks
// csr writes are always ready and take effect on the next request beat

module key_debounce_short_long_press (
   input  logic                              clock,
   input  logic                              reset,
   // request: [0] power_key_down, [1] mode_key_down, [2] dec_key_down,
   // [3] add_key_down, [4] powered_up, [5] interrupt_level, [7:6] zero
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,
   // response: [7:0] key_code, [8] disable_touch, [15:9] zero
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [15:0]                       rsp_tdata,
   // configuration write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [kdsl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                       csr_data
);
   import kdsl_pkg::*;

   logic [15:0] short_hold_ff;
   logic [15:0] long_hold_ff;
   logic        csr_write;
   logic        req_accept;
   logic        slot_free;
   item_type    item;
   result_type  step_result;
   result_type  rsp_data;

   // thresholds; the user is to write them only between items, the block itself does not enforce it
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         short_hold_ff <= SHORT_HOLD_RESET;
         long_hold_ff  <= LONG_HOLD_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SHORT_HOLD: short_hold_ff <= csr_data;
            CSR_LONG_HOLD:  long_hold_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // unpack the request beat
   assign item.power_key_down  = req_tdata[0];
   assign item.mode_key_down   = req_tdata[1];
   assign item.dec_key_down    = req_tdata[2];
   assign item.add_key_down    = req_tdata[3];
   assign item.powered_up      = req_tdata[4];
   assign item.interrupt_level = req_tdata[5];

   // take a beat whenever the result register can hold its answer
   assign req_tready = slot_free;
   assign req_accept = req_tvalid && req_tready;

   kdsl_fsm u_fsm (
      .clock            (clock),
      .reset            (reset),
      .accept           (req_accept),
      .item             (item),
      .short_hold_ticks (short_hold_ff),
      .long_hold_ticks  (long_hold_ff),
      .result           (step_result)
   );

   kdsl_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (req_accept),
      .load_data  (step_result),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_data   (rsp_data),
      .free       (slot_free)
   );

   assign rsp_tdata = {7'b0000000, rsp_data.disable_touch, rsp_data.key_code};

endmodule
